/* rtl/swfp_pkg.sv */
// Shared constants and types for the sliding window frame pacer.
`timescale 1ns / 1ps

package swfp_pkg;

  // Field widths of the item and result streams.
  localparam int TIME_W     = 32;
  localparam int FPS_W      = 8;
  localparam int SLEEP_W    = 20;
  localparam int RATE_W     = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  // Rate saturation value in 8.8 fixed point.
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Target rate after reset, in frames per second.
  localparam int RESET_FPS = 60;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WINDOW       = 256;
  localparam int DEF_TICKS_PER_SECOND = 1000000;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_EMIT,
    S_CFG_DIV,
    S_CFG_SUM,
    S_CFG_NUM
  } state_t;

endpackage

/* rtl/swfp_ring_mem.sv */
// Duration ring: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module swfp_ring_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-first: a read and a write to the same entry return the old value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/swfp_divider.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module swfp_divider #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // A zero divisor yields an all-ones quotient, which callers saturate.
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* rtl/sliding_window_frame_pacer.sv */
// Sliding window frame pacer: top level with sequencer, window state and result register.
`timescale 1ns / 1ps
// Processing: an accepted item updates the window sum and starts the shared bit-serial divider;
// the result register is loaded once the divider is done and the previous result has been taken.
// Items are handled one at a time: a new item is taken only after the last result is loaded.
// A configuration write occupies the block while the divider and then two multiplies run.
// Reset (synchronous, active low) loads a target of 60 frames per second and a full window.

module sliding_window_frame_pacer #(
  parameter int MAX_WINDOW       = swfp_pkg::DEF_MAX_WINDOW,
  parameter int TICKS_PER_SECOND = swfp_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                            clk,
  input  logic                            rst_n,

  // Configuration: target frames per second.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swfp_pkg::FPS_W-1:0]      cfg_data,

  // Input items. tdata: now_ticks[31:0].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swfp_pkg::IN_DATA_W-1:0]  in_tdata,

  // Result items.
  // tdata: sleep_ticks[19:0], frame_ticks[51:20], measured_rate_q8[67:52], zero pad[71:68].
  // tuser: late[0].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [swfp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  // Window length never exceeds the ring depth nor the 8-bit target rate.
  localparam int NMAX   = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
  localparam int NW     = $clog2(NMAX + 1);
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int FW     = $clog2(MAX_WINDOW + 1);
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W = NW + TPS_W;
  localparam int NUM_W  = PROD_W + 8;
  localparam int SUM_W  = swfp_pkg::TIME_W + FW;
  localparam int TIME_W = swfp_pkg::TIME_W;
  localparam int PAD_W  = swfp_pkg::OUT_DATA_W - swfp_pkg::SLEEP_W - TIME_W - swfp_pkg::RATE_W;
  localparam int FPS_W_LOCAL = swfp_pkg::FPS_W;

  // Reset window: the default target clipped to the ring depth.
  localparam int RESET_LEN = (swfp_pkg::RESET_FPS > MAX_WINDOW) ? MAX_WINDOW
                                                                : swfp_pkg::RESET_FPS;
  localparam int RESET_NOM = TICKS_PER_SECOND / RESET_LEN;
  localparam int RESET_SUM = RESET_LEN * RESET_NOM;

  swfp_pkg::state_t state_r, state_nxt;

  // Window state.
  logic [NW-1:0]     n_r;          // effective window length
  logic [TPS_W-1:0]  nom_r;        // nominal frame duration for that length
  logic [PROD_W-1:0] rate_num_r;   // window length times one second
  logic [SUM_W-1:0]  sum_r;        // running window sum
  logic [AW-1:0]     ptr_r;        // next ring slot to write
  logic [FW-1:0]     fill_r;       // durations written since the window restarted
  logic [TIME_W-1:0] last_r;       // previous frame-end timestamp

  // Per-item working registers.
  logic [TIME_W-1:0] dur_r;
  logic              hit_r;        // the evicted slot holds a real duration

  // Result register.
  logic                        out_tvalid_r;
  logic [swfp_pkg::SLEEP_W-1:0] sleep_r;
  logic [TIME_W-1:0]           frame_r;
  logic [swfp_pkg::RATE_W-1:0] rate_r;
  logic                        late_r;

  // Sequencer strobes.
  logic in_accept;
  logic cfg_accept;
  logic div_start;
  logic load_out;
  logic ring_rd;
  logic ring_wr;

  // Datapath signals.
  logic [FPS_W_LOCAL-1:0] fps_eff;
  logic [NW-1:0]          n_nxt;
  logic [AW:0]            evict_tmp;
  logic [AW-1:0]          evict_idx;
  logic [AW-1:0]          ptr_inc;
  logic [TIME_W-1:0]      ring_rd_data;
  logic [SUM_W-1:0]       evicted;
  logic [SUM_W-1:0]       sum_nxt;
  logic [PROD_W-1:0]      restart_sum;
  logic [PROD_W-1:0]      rate_num_nxt;
  logic [NUM_W-1:0]       div_num;
  logic [SUM_W-1:0]       div_den;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;
  logic                   late_c;
  logic [SUM_W-1:0]       remain_full;
  logic [TPS_W-1:0]       remain;
  logic [TPS_W-1:0]       sleep_full;
  logic [swfp_pkg::RATE_W-1:0] rate_sat;

  // ---------------------------------------------------------------------------
  // Sequencer. A configuration write wins over an item offered in the same
  // cycle; the item is simply taken once the restart sequence has finished.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swfp_pkg::S_IDLE: begin
        if (cfg_valid) begin
          state_nxt = swfp_pkg::S_CFG_DIV;
        end else if (in_tvalid) begin
          state_nxt = swfp_pkg::S_UPDATE;
        end
      end
      swfp_pkg::S_UPDATE: begin
        state_nxt = swfp_pkg::S_DIV;
      end
      swfp_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = swfp_pkg::S_EMIT;
        end
      end
      swfp_pkg::S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = swfp_pkg::S_IDLE;
        end
      end
      swfp_pkg::S_CFG_DIV: begin
        if (div_done) begin
          state_nxt = swfp_pkg::S_CFG_SUM;
        end
      end
      swfp_pkg::S_CFG_SUM: begin
        state_nxt = swfp_pkg::S_CFG_NUM;
      end
      swfp_pkg::S_CFG_NUM: begin
        state_nxt = swfp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = swfp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cfg_ready = 1'b0;
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    ring_wr   = 1'b0;
    unique case (state_r)
      swfp_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = !cfg_valid;
        div_start = cfg_valid;
      end
      swfp_pkg::S_UPDATE: begin
        ring_wr   = 1'b1;
        div_start = 1'b1;
      end
      swfp_pkg::S_EMIT: begin
        load_out = !out_tvalid_r || out_tready;
      end
      default: begin
        cfg_ready = 1'b0;
      end
    endcase
  end

  assign in_accept  = in_tvalid && in_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign ring_rd    = in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swfp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration: a written zero counts as one, and the window length is
  // clipped to the ring depth. The nominal duration is then found on the
  // shared divider, and the restart sum and rate numerator by one multiply each.
  // ---------------------------------------------------------------------------
  always_comb begin
    fps_eff = (cfg_data == '0) ? FPS_W_LOCAL'(1) : cfg_data;
    n_nxt   = (32'(fps_eff) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(fps_eff);
  end

  assign restart_sum  = PROD_W'(n_r) * PROD_W'(nom_r);
  assign rate_num_nxt = PROD_W'(n_r) * PROD_W'(TICKS_PER_SECOND);

  // ---------------------------------------------------------------------------
  // Ring addressing. The oldest entry of the window sits n slots behind the
  // write pointer. With a full-depth window that is the write slot itself;
  // the read, on acceptance, precedes the write, so the old value comes back.
  // ---------------------------------------------------------------------------
  always_comb begin
    evict_tmp = (AW+1)'(ptr_r) + (AW+1)'(MAX_WINDOW) - (AW+1)'(n_r);
    if (evict_tmp >= (AW+1)'(MAX_WINDOW)) begin
      evict_tmp = evict_tmp - (AW+1)'(MAX_WINDOW);
    end
    evict_idx = evict_tmp[AW-1:0];
    ptr_inc   = (ptr_r == AW'(MAX_WINDOW - 1)) ? '0 : ptr_r + AW'(1);
  end

  swfp_ring_mem #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (AW),
    .DATA_W (TIME_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (ptr_r),
    .wr_data (dur_r),
    .rd_en   (ring_rd),
    .rd_addr (evict_idx),
    .rd_data (ring_rd_data)
  );

  // Slots not yet written in this window count as the nominal duration.
  always_comb begin
    evicted = hit_r ? SUM_W'(ring_rd_data) : SUM_W'(nom_r);
    sum_nxt = sum_r - evicted + SUM_W'(dur_r);
  end

  // ---------------------------------------------------------------------------
  // Shared divider: nominal duration on a configuration write, and the
  // measured rate (length * one second * 256 / window sum) for each item.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_r == swfp_pkg::S_UPDATE) begin
      div_num = {rate_num_r, 8'b0};
      div_den = sum_nxt;
    end else begin
      div_num = NUM_W'(TICKS_PER_SECOND);
      div_den = SUM_W'(n_nxt);
    end
  end

  swfp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Result fields. The frame is late once the window reaches one second;
  // otherwise the sleep is the remainder of the second, capped at the
  // nominal duration. A zero window sum divides to all ones and saturates.
  // ---------------------------------------------------------------------------
  always_comb begin
    late_c      = sum_r >= SUM_W'(TICKS_PER_SECOND);
    remain_full = SUM_W'(TICKS_PER_SECOND) - sum_r;
    remain      = remain_full[TPS_W-1:0];
    sleep_full  = late_c ? '0 : ((remain < nom_r) ? remain : nom_r);
    rate_sat    = (|div_quot[NUM_W-1:swfp_pkg::RATE_W]) ? swfp_pkg::RATE_MAX
                                                         : div_quot[swfp_pkg::RATE_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // State registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r        <= NW'(RESET_LEN);
      nom_r      <= TPS_W'(RESET_NOM);
      sum_r      <= SUM_W'(RESET_SUM);
      rate_num_r <= PROD_W'(RESET_LEN) * PROD_W'(TICKS_PER_SECOND);
      ptr_r      <= '0;
      fill_r     <= '0;
      last_r     <= '0;
    end else begin
      if (cfg_accept) begin
        n_r    <= n_nxt;
        fill_r <= '0;
      end
      if (state_r == swfp_pkg::S_CFG_DIV && div_done) begin
        nom_r <= div_quot[TPS_W-1:0];
      end
      if (state_r == swfp_pkg::S_CFG_SUM) begin
        sum_r <= SUM_W'(restart_sum);
      end
      if (state_r == swfp_pkg::S_CFG_NUM) begin
        rate_num_r <= rate_num_nxt;
      end
      if (in_accept) begin
        last_r <= in_tdata[TIME_W-1:0];
      end
      if (state_r == swfp_pkg::S_UPDATE) begin
        sum_r <= sum_nxt;
        ptr_r <= ptr_inc;
        if (fill_r != FW'(MAX_WINDOW)) begin
          fill_r <= fill_r + FW'(1);
        end
      end
    end
  end

  // Frame duration wraps with the tick counter.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dur_r <= in_tdata[TIME_W-1:0] - last_r;
      hit_r <= fill_r >= FW'(n_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds a finished result until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sleep_r <= swfp_pkg::SLEEP_W'(sleep_full);
      frame_r <= dur_r;
      rate_r  <= rate_sat;
      late_r  <= late_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, rate_r, frame_r, sleep_r};
  assign out_tuser  = late_r;

endmodule
